// ===== sv/fpfb_pkg.sv =====
// fast packet frame builder package: mode and result codes, frame sizes,
// result beat type and the CAN identifier builder; depends on nothing
`default_nettype none

package fpfb_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 8;
  localparam int DATA_W      = FRAME_BYTES * 8;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int LEN_W       = POS_W + 1;
  localparam int ID_W        = 29;
  localparam int SEQ_W       = 3;
  localparam int FRM_W       = 5;

  // first PDU2 format value
  localparam logic [7:0] PDU2_FIRST = 8'd240;

  // input item codes
  typedef enum logic [2:0] {
    MODE_START_SINGLE  = 3'd0,
    MODE_START_FAST    = 3'd1,
    MODE_DATA          = 3'd2,
    MODE_FINISH_SINGLE = 3'd3,
    MODE_FINISH_FAST   = 3'd4
  } mode_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_FRAME     = 2'd0,
    KIND_DROPPED   = 2'd1,
    KIND_WRONG_END = 2'd2
  } kind_t;

  // one result beat
  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  frame_length;
  } out_beat_t;

  // 29-bit identifier from group number, priority and addresses
  function automatic logic [ID_W-1:0] make_id(
    input logic [16:0] pgn,
    input logic [2:0]  prio,
    input logic [7:0]  src,
    input logic [7:0]  dst
  );
    logic [ID_W-1:0] base;
    base = {prio, 26'd0} | {4'd0, pgn, 8'd0} | {21'd0, src};
    if (pgn[15:8] < PDU2_FIRST) begin
      if (pgn[7:0] != 8'd0) begin
        return '0;
      end
      return base | {13'd0, dst, 8'd0};
    end
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== sv/fast_packet_frame_builder_unit.sv =====
// fast packet frame builder top level: packet state, frame packing and
// output register with one skid stage; depends on fpfb_pkg
//
// Takes one item per clock while in_stall is low: start (single or fast
// packet), data byte or finish. A start builds the 29-bit CAN identifier
// and opens a packet; data bytes are packed into 8-byte frames, fast packet
// frames led by a sequence/frame-counter byte, the first one also by the
// total length. A full fast frame leaves on the data beat that fills it, the
// rest on finish. Every item is handled by the state update logic feeding
// the result register, so a new item is accepted each clock while in_stall
// is low. The output register plus a one-entry skid stage lets an item enter
// while a result waits; in_stall rises only when the skid stage is full.
`default_nettype none

module fast_packet_frame_builder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_mode,
  input  wire logic [16:0]                   in_pgn,
  input  wire logic [2:0]                    in_priority_req,
  input  wire logic [7:0]                    in_source,
  input  wire logic [7:0]                    in_destination,
  input  wire logic [7:0]                    in_total_length,
  input  wire logic [7:0]                    in_data_byte,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_kind,
  output logic [fpfb_pkg::ID_W-1:0]          out_frame_id,
  output logic [fpfb_pkg::DATA_W-1:0]        out_frame_data,
  output logic [fpfb_pkg::LEN_W-1:0]         out_frame_length
);
  import fpfb_pkg::*;

  // packet state
  logic              is_fast_r,    is_fast_nxt;
  logic [LEN_W-1:0]  byte_cnt_r,   byte_cnt_nxt;
  logic [SEQ_W-1:0]  seq_cnt_r,    seq_cnt_nxt;
  logic [FRM_W-1:0]  frm_cnt_r,    frm_cnt_nxt;
  logic [DATA_W-1:0] store_r,      store_nxt;
  logic [ID_W-1:0]   hdr_id_r,     hdr_id_nxt;

  // output and skid stages
  logic      out_vld_r, skid_vld_r;
  out_beat_t out_r, skid_r;

  logic      in_acc;
  logic      out_take;
  logic      res_vld;
  out_beat_t res;
  logic [SEQ_W-1:0]  seq_new;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] store_put;
  logic [ID_W-1:0]   new_id;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_take = out_vld_r && !out_stall;

  assign seq_new = seq_cnt_r + SEQ_W'(1);
  assign pos     = byte_cnt_r[POS_W-1:0];
  assign new_id  = make_id(in_pgn, in_priority_req, in_source, in_destination);

  // data byte merged into its lane
  always_comb begin
    store_put = store_r;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (pos == POS_W'(i)) begin
        store_put[i*8 +: 8] = store_r[i*8 +: 8] | in_data_byte;
      end
    end
  end

  // state update and result for the accepted item
  always_comb begin
    is_fast_nxt  = is_fast_r;
    byte_cnt_nxt = byte_cnt_r;
    seq_cnt_nxt  = seq_cnt_r;
    frm_cnt_nxt  = frm_cnt_r;
    store_nxt    = store_r;
    hdr_id_nxt   = hdr_id_r;
    res_vld      = 1'b0;
    res          = '0;
    case (in_mode)
      MODE_START_SINGLE: begin
        hdr_id_nxt   = new_id;
        is_fast_nxt  = 1'b0;
        byte_cnt_nxt = '0;
        store_nxt    = '0;
      end
      MODE_START_FAST: begin
        hdr_id_nxt   = new_id;
        is_fast_nxt  = 1'b1;
        seq_cnt_nxt  = seq_new;
        frm_cnt_nxt  = FRM_W'(1);
        store_nxt    = {{(DATA_W-16){1'b0}}, in_total_length, seq_new, {FRM_W{1'b0}}};
        byte_cnt_nxt = LEN_W'(2);
      end
      MODE_DATA: begin
        if (byte_cnt_r < LEN_W'(FRAME_BYTES)) begin
          if (is_fast_r && byte_cnt_r == LEN_W'(FRAME_BYTES - 1)) begin
            // fast frame full: send it and open the next one
            res_vld          = 1'b1;
            res.kind         = KIND_FRAME;
            res.frame_id     = hdr_id_r;
            res.frame_data   = store_put;
            res.frame_length = LEN_W'(FRAME_BYTES);
            store_nxt        = {{(DATA_W-8){1'b0}}, seq_cnt_r, frm_cnt_r};
            frm_cnt_nxt      = frm_cnt_r + FRM_W'(1);
            byte_cnt_nxt     = LEN_W'(1);
          end else begin
            store_nxt    = store_put;
            byte_cnt_nxt = byte_cnt_r + LEN_W'(1);
          end
        end else begin
          res_vld  = 1'b1;
          res.kind = KIND_DROPPED;
        end
      end
      MODE_FINISH_SINGLE: begin
        if (is_fast_r) begin
          res_vld  = 1'b1;
          res.kind = KIND_WRONG_END;
        end else if (byte_cnt_r != '0) begin
          res_vld          = 1'b1;
          res.kind         = KIND_FRAME;
          res.frame_id     = hdr_id_r;
          res.frame_data   = store_r;
          res.frame_length = byte_cnt_r;
        end
      end
      MODE_FINISH_FAST: begin
        if (!is_fast_r) begin
          res_vld  = 1'b1;
          res.kind = KIND_WRONG_END;
        end else if (byte_cnt_r > LEN_W'(1)) begin
          res_vld          = 1'b1;
          res.kind         = KIND_FRAME;
          res.frame_id     = hdr_id_r;
          res.frame_data   = store_r;
          res.frame_length = byte_cnt_r;
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  // packet state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_fast_r  <= 1'b0;
      byte_cnt_r <= '0;
      seq_cnt_r  <= '0;
      frm_cnt_r  <= '0;
      store_r    <= '0;
      hdr_id_r   <= '0;
    end else if (in_acc) begin
      is_fast_r  <= is_fast_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      seq_cnt_r  <= seq_cnt_nxt;
      frm_cnt_r  <= frm_cnt_nxt;
      store_r    <= store_nxt;
      hdr_id_r   <= hdr_id_nxt;
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc && res_vld) begin
      if (out_vld_r && !out_take) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc && res_vld) begin
      if (out_vld_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_frame_id     = out_r.frame_id;
  assign out_frame_data   = out_r.frame_data;
  assign out_frame_length = out_r.frame_length;

  // skid stage only fills behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a beat while output is empty");

  // a fast packet never rests on a full frame
  a_fast_count: assert property (@(posedge clk) disable iff (!rst_n)
    is_fast_r |-> (byte_cnt_r != '0 && byte_cnt_r < LEN_W'(FRAME_BYTES)))
    else $error("fast packet byte count out of range");

  // byte count never passes a frame
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= LEN_W'(FRAME_BYTES))
    else $error("byte count above frame size");

  // flag beats carry no frame
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.kind != KIND_FRAME) |->
      (out_r.frame_length == '0 && out_r.frame_data == '0 && out_r.frame_id == '0))
    else $error("flag beat carries frame payload");

  // a full skid stage drains when the output beat is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_stall) |=> (!skid_vld_r && out_vld_r))
    else $error("skid stage did not drain");

endmodule

`default_nettype wire
